FILE: sv/asr_pkg.sv
package asr_pkg;

    // Storage and sample sizing
    localparam int SEGMENT_DEPTH = 4096;
    localparam int SAMPLE_BITS   = 24;
    localparam int ADDR_W        = $clog2(SEGMENT_DEPTH);
    localparam int LEN_W         = $clog2(SEGMENT_DEPTH + 1);

    // Configuration register widths
    localparam int SEG_LEN_W  = 13;
    localparam int REPEAT_W   = 8;
    localparam int GAIN_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Mix arithmetic: Q1.15 gains, round half up
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = SAMPLE_BITS + GAIN_W + 1;
    localparam int ACC_W     = PROD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEG_LEN = 2'd0,
        CFG_REPEAT  = 2'd1,
        CFG_DRY     = 2'd2,
        CFG_WET     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
        logic                          restart;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
    } t_out_word;

    typedef struct packed {
        logic [GAIN_W-1:0] dry;
        logic [GAIN_W-1:0] wet;
    } t_gains;

    typedef struct packed {
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [SAMPLE_BITS-1:0] wr_data;
    } t_mem_req;

endpackage

FILE: sv/asr_ram.sv
module asr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read and write to one address in a cycle returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/asr_seq.sv
module asr_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [asr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_accept,
    input  asr_pkg::t_in_word                 i_in,
    output logic                              o_busy,
    output asr_pkg::t_mem_req                 o_mem,
    output asr_pkg::t_gains                   o_gains
);

    import asr_pkg::*;

    logic [SEG_LEN_W-1:0] r_seg_len;
    logic [REPEAT_W-1:0]  r_repeat;
    logic [GAIN_W-1:0]    r_dry;
    logic [GAIN_W-1:0]    r_wet;

    logic [ADDR_W-1:0]    r_pos;
    logic [REPEAT_W-1:0]  r_replays;
    logic                 r_replaying;
    logic                 r_clr_busy;
    logic [ADDR_W-1:0]    r_clr_addr;

    logic [ADDR_W-1:0]    n_pos;
    logic [REPEAT_W-1:0]  n_replays;
    logic                 n_replaying;

    logic [LEN_W-1:0]       eff_len;
    logic [REPEAT_W-1:0]    eff_target;
    logic [ADDR_W-1:0]      pos_cur;
    logic [LEN_W-1:0]       pos_inc;
    logic [REPEAT_W-1:0]    replays_inc;
    logic [SAMPLE_BITS:0]   mono_sum;
    logic                   clr_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= SEG_LEN_W'(99);
            r_repeat  <= REPEAT_W'(42);
            r_dry     <= GAIN_W'(32768);
            r_wet     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SEG_LEN: r_seg_len <= i_cfg_data[SEG_LEN_W-1:0];
                CFG_REPEAT:  r_repeat  <= i_cfg_data[REPEAT_W-1:0];
                CFG_DRY:     r_dry     <= i_cfg_data[GAIN_W-1:0];
                CFG_WET:     r_wet     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length and replay count
    always_comb begin
        if (32'(r_seg_len) > 32'(SEGMENT_DEPTH)) begin
            eff_len = LEN_W'(SEGMENT_DEPTH);
        end else if (r_seg_len == '0) begin
            eff_len = LEN_W'(1);
        end else begin
            eff_len = LEN_W'(r_seg_len);
        end
        eff_target = (r_repeat == '0) ? REPEAT_W'(1) : r_repeat;
    end

    // Segment position and phase sequencing
    always_comb begin
        pos_cur     = i_in.restart ? '0 : r_pos;
        pos_inc     = LEN_W'(pos_cur) + LEN_W'(1);
        replays_inc = r_replays + REPEAT_W'(1);
        n_pos       = pos_inc[ADDR_W-1:0];
        n_replays   = r_replays;
        n_replaying = r_replaying;
        if (pos_inc >= eff_len) begin
            n_pos = '0;
            if (r_replaying) begin
                if (replays_inc >= eff_target) begin
                    n_replays   = '0;
                    n_replaying = 1'b0;
                end else begin
                    n_replays = replays_inc;
                end
            end else begin
                n_replaying = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_replays   <= '0;
            r_replaying <= 1'b0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_replays   <= n_replays;
            r_replaying <= n_replaying;
        end
    end

    // Clearing pass over the segment memory after reset
    assign clr_last = (32'(r_clr_addr) == 32'(SEGMENT_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (clr_last) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Mono word: floor((left + right) / 2)
    assign mono_sum = {i_in.sample_left[SAMPLE_BITS-1], i_in.sample_left}
                    + {i_in.sample_right[SAMPLE_BITS-1], i_in.sample_right};

    // Memory access: read the stored word, write while recording or clearing
    always_comb begin
        o_mem.rd_en   = i_accept;
        o_mem.rd_addr = pos_cur;
        if (r_clr_busy) begin
            o_mem.wr_en   = 1'b1;
            o_mem.wr_addr = r_clr_addr;
            o_mem.wr_data = '0;
        end else begin
            o_mem.wr_en   = i_accept && !r_replaying;
            o_mem.wr_addr = pos_cur;
            o_mem.wr_data = mono_sum[SAMPLE_BITS:1];
        end
    end

    assign o_busy      = r_clr_busy;
    assign o_gains.dry = r_dry;
    assign o_gains.wet = r_wet;

    // No word enters while the memory is still being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_accept)
        else $error("word accepted during clearing pass");

    // Memory is written only by the clearing pass or while recording
    a_write_when_recording: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.wr_en |-> (r_clr_busy || (i_accept && !r_replaying)))
        else $error("segment memory written while replaying");

    // Leaving the replay phase restarts the replay count
    a_replays_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_replaying) |-> (r_replays == '0))
        else $error("replay count not cleared on return to recording");

    // A phase change only happens at a segment boundary
    a_phase_at_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (n_replaying != r_replaying)) |=> (r_pos == '0))
        else $error("phase changed away from a segment boundary");

endmodule

FILE: sv/asr_mix.sv
module asr_mix (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  asr_pkg::t_in_word                    i_in,
    input  logic [asr_pkg::SAMPLE_BITS-1:0]      i_stored,
    input  asr_pkg::t_gains                      i_gains,
    input  logic                                 i_stall,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output asr_pkg::t_out_word                   o_out
);

    import asr_pkg::*;

    // Stage 1: inputs aligned with the memory read data
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_left;
    logic signed [SAMPLE_BITS-1:0] r_s1_right;

    // Stage 2: registered products
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_p_dl;
    logic signed [PROD_W-1:0] r_p_wl;
    logic signed [PROD_W-1:0] r_p_dr;
    logic signed [PROD_W-1:0] r_p_wr;

    // Output register
    logic      r_out_valid;
    t_out_word r_out;

    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic s1_adv;
    logic s2_adv;

    logic signed [PROD_W-1:0]      n_p_dl;
    logic signed [PROD_W-1:0]      n_p_wl;
    logic signed [PROD_W-1:0]      n_p_dr;
    logic signed [PROD_W-1:0]      n_p_wr;
    logic signed [GAIN_W:0]        dry_s;
    logic signed [GAIN_W:0]        wet_s;
    logic signed [SAMPLE_BITS-1:0] stored_s;
    logic signed [SAMPLE_BITS-1:0] n_left;
    logic signed [SAMPLE_BITS-1:0] n_right;

    function automatic logic signed [SAMPLE_BITS-1:0] mix_round(
        input logic signed [PROD_W-1:0] p_dry,
        input logic signed [PROD_W-1:0] p_wet
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shr;
        logic [ACC_W-SAMPLE_BITS:0] top;
        logic signed [SAMPLE_BITS-1:0] res;
        acc = ACC_W'(p_dry) + ACC_W'(p_wet) + ACC_W'(1 << (FRAC_BITS - 1));
        shr = acc >>> FRAC_BITS;
        top = shr[ACC_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top)) begin
            res = shr[SAMPLE_BITS-1:0];
        end else if (shr[ACC_W-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    // Stall chain back from the output register
    assign s3_free = !r_out_valid || !i_stall;
    assign s2_adv  = r_s2_valid && s3_free;
    assign s2_free = !r_s2_valid || s3_free;
    assign s1_adv  = r_s1_valid && s2_free;
    assign s1_free = !r_s1_valid || s2_free;
    assign o_ready = s1_free;

    // Gain products; the two wet products share one multiplier
    always_comb begin
        dry_s    = $signed({1'b0, i_gains.dry});
        wet_s    = $signed({1'b0, i_gains.wet});
        stored_s = $signed(i_stored);
        n_p_dl   = PROD_W'(dry_s) * PROD_W'(r_s1_left);
        n_p_dr   = PROD_W'(dry_s) * PROD_W'(r_s1_right);
        n_p_wl   = PROD_W'(wet_s) * PROD_W'(stored_s);
        n_p_wr   = n_p_wl;
    end

    // Sum, round and saturate
    always_comb begin
        n_left  = mix_round(r_p_dl, r_p_wl);
        n_right = mix_round(r_p_dr, r_p_wr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_left  <= i_in.sample_left;
            r_s1_right <= i_in.sample_right;
        end
        if (s1_adv) begin
            r_p_dl <= n_p_dl;
            r_p_wl <= n_p_wl;
            r_p_dr <= n_p_dr;
            r_p_wr <= n_p_wr;
        end
        if (s2_adv) begin
            r_out.out_left  <= n_left;
            r_out.out_right <= n_right;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // A word is taken into stage 1 only when that stage can make room
    a_accept_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> s1_free)
        else $error("word accepted with stage 1 blocked");

    // Products held while the output side stalls
    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_free) |=> (r_s2_valid && $stable(r_p_dl) && $stable(r_p_wl)))
        else $error("stage 2 lost its products under stall");

    // A stage 1 word that cannot move keeps its samples
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_free) |=> (r_s1_valid && $stable(r_s1_left)))
        else $error("stage 1 word lost under stall");

endmodule

FILE: sv/audio_stutter_repeater.sv
// Stutter / beat-repeat effect on a stereo 24-bit stream. While recording, the
// mono mix floor((left + right) / 2) is written into a 4096-word segment memory
// at the current position; after segment_length words the block replays that
// segment repeat_target times (at least once) and then records again. Each output
// channel is dry_gain * input + wet_gain * stored word in Q1.15, rounded half up
// and saturated to 24 bits; the stored word is the one read before this word's
// write. A set restart bit moves the position to zero before the word is used.
// One word is taken every clock while o_stall is low; an accepted word passes
// memory read with the input register, the multiply stage, then sum/saturate
// into the output register, and the output register lets a new word enter
// while a result waits.
// After reset the segment memory is cleared one word per cycle, so input is
// held off (o_stall high) until the clearing pass is done; configuration writes
// are taken at any time and should be made only while the block is idle.
module audio_stutter_repeater (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [asr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [asr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  asr_pkg::t_in_word                 i_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output asr_pkg::t_out_word                o_out
);

    import asr_pkg::*;

    logic                   accept;
    logic                   seq_busy;
    logic                   mix_ready;
    t_mem_req               mem_req;
    t_gains                 gains;
    logic [SAMPLE_BITS-1:0] stored;

    // Input handshake
    assign o_stall = seq_busy || !mix_ready;
    assign accept  = i_valid && !o_stall;

    asr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_busy      (seq_busy),
        .o_mem       (mem_req),
        .o_gains     (gains)
    );

    asr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SEGMENT_DEPTH)
    ) u_segment_mem (
        .i_clk   (i_clk),
        .i_we    (mem_req.wr_en),
        .i_waddr (mem_req.wr_addr),
        .i_wdata (mem_req.wr_data),
        .i_re    (mem_req.rd_en),
        .i_raddr (mem_req.rd_addr),
        .o_rdata (stored)
    );

    asr_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .i_stored (stored),
        .i_gains  (gains),
        .i_stall  (i_stall),
        .o_ready  (mix_ready),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule
